// ===== rtl/qeru_pkg.sv =====
// ----------------------------------------------------------------------------
// qeru_pkg
// Shared request/response types and fixed angle constants for the
// incremental quaternion rotation datapath.
// ----------------------------------------------------------------------------
package qeru_pkg;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic signed [15:0] step_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] res_w;
      logic signed [15:0] res_x;
      logic signed [15:0] res_y;
      logic signed [15:0] res_z;
      logic               saturated;
   } rsp_type;

   // angles in units of 2^-30 rad
   localparam int ANG_W = 40;
   localparam logic signed [ANG_W-1:0] ANG_PI      = 40'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 40'sd6746518852;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 40'sd1686629713;
   localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 40'sd652032874;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 40'sh3243F6A8;
         5'd1:  v = 40'sh1DAC6705;
         5'd2:  v = 40'sh0FADBAFC;
         5'd3:  v = 40'sh07F56EA6;
         5'd4:  v = 40'sh03FEAB76;
         5'd5:  v = 40'sh01FFD55B;
         5'd6:  v = 40'sh00FFFAAA;
         5'd7:  v = 40'sh007FFF55;
         5'd8:  v = 40'sh003FFFEA;
         5'd9:  v = 40'sh001FFFFD;
         5'd10: v = 40'sh000FFFFF;
         5'd11: v = 40'sh0007FFFF;
         5'd12: v = 40'sh0003FFFF;
         5'd13: v = 40'sh0001FFFF;
         5'd14: v = 40'sh0000FFFF;
         5'd15: v = 40'sh00007FFF;
         5'd16: v = 40'sh00003FFF;
         5'd17: v = 40'sh00001FFF;
         5'd18: v = 40'sh00000FFF;
         5'd19: v = 40'sh000007FF;
         5'd20: v = 40'sh000003FF;
         5'd21: v = 40'sh000001FF;
         5'd22: v = 40'sh000000FF;
         5'd23: v = 40'sh0000007F;
         5'd24: v = 40'sh0000003F;
         5'd25: v = 40'sh0000001F;
         5'd26: v = 40'sh0000000F;
         5'd27: v = 40'sh00000008;
         5'd28: v = 40'sh00000004;
         5'd29: v = 40'sh00000002;
         5'd30: v = 40'sh00000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/quaternion_euler_rotate_update.sv =====
// Throughput: one request per cycle; busy stays low, every stage advances each
//    cycle because the receiver cannot stall the result strobe.
// Reset: synchronous active-high reset clears all stage valid bits; payload
//    registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_euler_rotate_update
// Rotate an orientation quaternion by three scaled Euler half angles using an
// unrolled CORDIC and a registered multiplier tree.
// ----------------------------------------------------------------------------
module quaternion_euler_rotate_update
   import qeru_pkg::*;
#(
   parameter int DATA_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int FRAC  = DATA_WIDTH - 1;
   localparam int TW    = DATA_WIDTH + 1;        // trig / product width
   localparam int PW    = 2 * TW;                // product before rounding
   localparam int NS    = CORDIC_STAGES;
   localparam int ACCW  = 16 + TW + 3;           // final accumulator is ACCW + 3 bits wide
   localparam int SH    = 30 - FRAC;             // CORDIC to FRAC shift

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [TW-1:0]    trig_type;
   typedef logic signed [15:0]      q_type;

   // the pipeline never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // Stage A: scale rates by step (half angle in 2^-30 units)
   // ---------------------------------------------------------------------
   logic                 a_vld_ff;
   ang_type              a_ang_ff [3];
   q_type                a_q_ff   [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      a_ang_ff[0] <= ANG_W'(32'(req_data.rate_x * req_data.step_angle)) <<< 5;
      a_ang_ff[1] <= ANG_W'(32'(req_data.rate_y * req_data.step_angle)) <<< 5;
      a_ang_ff[2] <= ANG_W'(32'(req_data.rate_z * req_data.step_angle)) <<< 5;
      a_q_ff[0]   <= req_data.quat_w;
      a_q_ff[1]   <= req_data.quat_x;
      a_q_ff[2]   <= req_data.quat_y;
      a_q_ff[3]   <= req_data.quat_z;
   end

   // ---------------------------------------------------------------------
   // Stage B: wrap into [-pi, pi). |a| <= 2^35 so k lies in -6..6; pick it by
   // compares against precomputed boundaries (odd multiples of pi).
   // ---------------------------------------------------------------------
   logic    b_vld_ff;
   ang_type b_ang_ff [3];
   q_type   b_q_ff   [4];

   function automatic ang_type wrap_angle(input ang_type a);
      ang_type r;
      r = a;
      for (int k = -6; k <= 6; k++) begin
         if (a >= ANG_W'(2 * k - 1) * ANG_PI && a < ANG_W'(2 * k + 1) * ANG_PI) begin
            r = a - ANG_W'(k) * ANG_TWO_PI;
         end
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         b_ang_ff[i] <= wrap_angle(a_ang_ff[i]);
      end
      b_q_ff <= a_q_ff;
   end

   // ---------------------------------------------------------------------
   // Stage C: fold into [-pi/2, pi/2], remember negation
   // ---------------------------------------------------------------------
   logic    c_vld_ff;
   ang_type c_z_ff [3];
   logic    c_neg_ff [3];
   q_type   c_q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (b_ang_ff[i] > ANG_HALF_PI) begin
            c_z_ff[i]   <= b_ang_ff[i] - ANG_PI;
            c_neg_ff[i] <= 1'b1;
         end else if (b_ang_ff[i] < -ANG_HALF_PI) begin
            c_z_ff[i]   <= b_ang_ff[i] + ANG_PI;
            c_neg_ff[i] <= 1'b1;
         end else begin
            c_z_ff[i]   <= b_ang_ff[i];
            c_neg_ff[i] <= 1'b0;
         end
      end
      c_q_ff <= b_q_ff;
   end

   // ---------------------------------------------------------------------
   // CORDIC: one registered micro-rotation per stage, three lanes
   // ---------------------------------------------------------------------
   logic    cr_vld_ff [1:NS];
   ang_type cr_x_ff   [1:NS][3];
   ang_type cr_y_ff   [1:NS][3];
   ang_type cr_z_ff   [1:NS][3];
   logic    cr_neg_ff [1:NS][3];
   q_type   cr_q_ff   [1:NS][4];

   for (genvar s = 0; s < NS; s++) begin : g_cordic
      localparam int SI = (s < 63) ? s : 63;

      logic    cur_vld;
      ang_type cur_x   [3];
      ang_type cur_y   [3];
      ang_type cur_z   [3];
      logic    cur_neg [3];
      q_type   cur_q   [4];

      // first stage starts from the gain on x and the folded angle
      if (s == 0) begin : g_head
         always_comb begin
            cur_vld = c_vld_ff;
            for (int l = 0; l < 3; l++) begin
               cur_x[l]   = CORDIC_GAIN;
               cur_y[l]   = '0;
               cur_z[l]   = c_z_ff[l];
               cur_neg[l] = c_neg_ff[l];
            end
            cur_q = c_q_ff;
         end
      end else begin : g_body
         always_comb begin
            cur_vld = cr_vld_ff[s];
            for (int l = 0; l < 3; l++) begin
               cur_x[l]   = cr_x_ff[s][l];
               cur_y[l]   = cr_y_ff[s][l];
               cur_z[l]   = cr_z_ff[s][l];
               cur_neg[l] = cr_neg_ff[s][l];
            end
            cur_q = cr_q_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cr_vld_ff[s+1] <= 1'b0;
         end else begin
            cr_vld_ff[s+1] <= cur_vld;
         end
      end
      always_ff @(posedge clock) begin
         for (int l = 0; l < 3; l++) begin
            if (cur_z[l] >= 0) begin
               cr_x_ff[s+1][l] <= cur_x[l] - (cur_y[l] >>> SI);
               cr_y_ff[s+1][l] <= cur_y[l] + (cur_x[l] >>> SI);
               cr_z_ff[s+1][l] <= cur_z[l] - ((s < 32) ? atan_entry(5'(s)) : '0);
            end else begin
               cr_x_ff[s+1][l] <= cur_x[l] + (cur_y[l] >>> SI);
               cr_y_ff[s+1][l] <= cur_y[l] - (cur_x[l] >>> SI);
               cr_z_ff[s+1][l] <= cur_z[l] + ((s < 32) ? atan_entry(5'(s)) : '0);
            end
            cr_neg_ff[s+1][l] <= cur_neg[l];
         end
         cr_q_ff[s+1] <= cur_q;
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: negate if folded, round to FRAC bits
   // ---------------------------------------------------------------------
   function automatic trig_type to_frac(input ang_type v);
      ang_type r;
      if (SH > 0) begin
         r = (v + (ANG_W'(1) <<< (SH - 1))) >>> SH;
      end else begin
         r = v <<< (-SH);
      end
      return TW'(r);
   endfunction

   logic     d_vld_ff;
   trig_type d_s_ff [3];
   trig_type d_c_ff [3];
   q_type    d_q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= cr_vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         if (cr_neg_ff[NS][l]) begin
            d_c_ff[l] <= to_frac(-cr_x_ff[NS][l]);
            d_s_ff[l] <= to_frac(-cr_y_ff[NS][l]);
         end else begin
            d_c_ff[l] <= to_frac(cr_x_ff[NS][l]);
            d_s_ff[l] <= to_frac(cr_y_ff[NS][l]);
         end
      end
      d_q_ff <= cr_q_ff[NS];
   end

   // ---------------------------------------------------------------------
   // Stage E/F: pair products, then triple products
   // pairs: cx*cy, sx*sy, sx*cy, cx*sy
   // ---------------------------------------------------------------------
   function automatic trig_type mulr(input trig_type a, input trig_type b);
      logic signed [PW-1:0] p;
      p = (PW'(a) * PW'(b)) + (PW'(1) <<< (FRAC - 1));
      return TW'(p >>> FRAC);
   endfunction

   logic     e_vld_ff;
   trig_type e_pr_ff [4];
   trig_type e_sz_ff, e_cz_ff;
   q_type    e_q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_pr_ff[0] <= mulr(d_c_ff[0], d_c_ff[1]);
      e_pr_ff[1] <= mulr(d_s_ff[0], d_s_ff[1]);
      e_pr_ff[2] <= mulr(d_s_ff[0], d_c_ff[1]);
      e_pr_ff[3] <= mulr(d_c_ff[0], d_s_ff[1]);
      e_sz_ff    <= d_s_ff[2];
      e_cz_ff    <= d_c_ff[2];
      e_q_ff     <= d_q_ff;
   end

   logic     f_vld_ff;
   trig_type f_t_ff [8];
   q_type    f_q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_t_ff[0] <= mulr(e_pr_ff[0], e_cz_ff);  // cx cy cz
      f_t_ff[1] <= mulr(e_pr_ff[1], e_sz_ff);  // sx sy sz
      f_t_ff[2] <= mulr(e_pr_ff[2], e_cz_ff);  // sx cy cz
      f_t_ff[3] <= mulr(e_pr_ff[3], e_sz_ff);  // cx sy sz
      f_t_ff[4] <= mulr(e_pr_ff[3], e_cz_ff);  // cx sy cz
      f_t_ff[5] <= mulr(e_pr_ff[2], e_sz_ff);  // sx cy sz
      f_t_ff[6] <= mulr(e_pr_ff[0], e_sz_ff);  // cx cy sz
      f_t_ff[7] <= mulr(e_pr_ff[1], e_cz_ff);  // sx sy cz
      f_q_ff    <= e_q_ff;
   end

   // ---------------------------------------------------------------------
   // Stage G: delta quaternion
   // ---------------------------------------------------------------------
   localparam int DW = TW + 1;
   typedef logic signed [DW-1:0] dq_type;

   logic   g_vld_ff;
   dq_type g_d_ff [4];
   q_type  g_q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      g_d_ff[0] <= DW'(f_t_ff[0]) + DW'(f_t_ff[1]);
      g_d_ff[1] <= DW'(f_t_ff[2]) - DW'(f_t_ff[3]);
      g_d_ff[2] <= DW'(f_t_ff[4]) + DW'(f_t_ff[5]);
      g_d_ff[3] <= DW'(f_t_ff[6]) - DW'(f_t_ff[7]);
      g_q_ff    <= f_q_ff;
   end

   // ---------------------------------------------------------------------
   // Stage H: sixteen partial products of the Hamilton product
   // ---------------------------------------------------------------------
   localparam int MW = 16 + DW;
   typedef logic signed [MW-1:0] mp_type;

   logic   h_vld_ff;
   mp_type h_p_ff [4][4];   // [q index][d index]

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            h_p_ff[i][j] <= MW'(g_q_ff[i]) * MW'(g_d_ff[j]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage I: sum, round, saturate, drive result strobe
   // ---------------------------------------------------------------------
   typedef logic signed [ACCW+2:0] acc_type;

   function automatic logic [16:0] finish(input acc_type acc);
      acc_type r;
      logic    sat;
      q_type   v;
      r = (acc + (($bits(acc_type))'(1) <<< (FRAC - 1))) >>> FRAC;
      sat = 1'b0;
      if (r > 32767) begin
         v = 16'sh7FFF;
         sat = 1'b1;
      end else if (r < -32768) begin
         v = 16'sh8000;
         sat = 1'b1;
      end else begin
         v = 16'(r);
      end
      return {sat, v};
   endfunction

   acc_type     acc_w, acc_x, acc_y, acc_z;
   logic [16:0] fin_w, fin_x, fin_y, fin_z;

   always_comb begin
      acc_w = acc_type'(h_p_ff[0][0]) - acc_type'(h_p_ff[1][1])
            - acc_type'(h_p_ff[2][2]) - acc_type'(h_p_ff[3][3]);
      acc_x = acc_type'(h_p_ff[0][1]) + acc_type'(h_p_ff[1][0])
            + acc_type'(h_p_ff[2][3]) - acc_type'(h_p_ff[3][2]);
      acc_y = acc_type'(h_p_ff[0][2]) - acc_type'(h_p_ff[1][3])
            + acc_type'(h_p_ff[2][0]) + acc_type'(h_p_ff[3][1]);
      acc_z = acc_type'(h_p_ff[0][3]) + acc_type'(h_p_ff[1][2])
            - acc_type'(h_p_ff[2][1]) + acc_type'(h_p_ff[3][0]);
      fin_w = finish(acc_w);
      fin_x = finish(acc_x);
      fin_y = finish(acc_y);
      fin_z = finish(acc_z);
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.res_w     <= fin_w[15:0];
      rsp_data_ff.res_x     <= fin_x[15:0];
      rsp_data_ff.res_y     <= fin_y[15:0];
      rsp_data_ff.res_z     <= fin_z[15:0];
      rsp_data_ff.saturated <= fin_w[16] | fin_x[16] | fin_y[16] | fin_z[16];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/tb_quaternion_euler_rotate_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_euler_rotate_update
// Self-checking bench for the incremental quaternion rotation block: drives
// directed corner requests and random requests, predicts each response with
// a bit-exact fixed-point rotation model, and compares responses in order.
// ----------------------------------------------------------------------------
module tb_quaternion_euler_rotate_update;
   import qeru_pkg::*;

   localparam int    DW     = 16;
   localparam int    STAGES = 16;
   localparam int    FRAC   = DW - 1;
   localparam int    LAT    = STAGES + 9;
   localparam int    N_RAND = 1300;

   // ------------------------------------------------------------------------
   // Rotation predictor: angle wrap, CORDIC sin/cos, delta quaternion,
   // Hamilton product, round and clip to Q1.15.
   // ------------------------------------------------------------------------
   class rotation_scoreboard;
      rsp_type pending_rsp[$];
      int      mismatches;

      function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function longint round_shift(longint v, int s);
         if (s == 0) return v;
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint mul_round(longint a, longint b);
         return round_shift(a * b, FRAC);
      endfunction

      function longint triple(longint a, longint b, longint c);
         return mul_round(mul_round(a, b), c);
      endfunction

      function longint atan_step(int i);
         longint tab[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
         return tab[i];
      endfunction

      function void half_angle_trig(longint ang, output longint s, output longint c);
         longint pi_u, two_pi, half_pi, t, k, x, y, nx;
         bit flip;
         pi_u    = 64'sd3373259426;
         two_pi  = 64'sd6746518852;
         half_pi = 64'sd1686629713;
         t = ang + pi_u;
         if (t >= 0) k = t / two_pi;
         else        k = -((-t + two_pi - 1) / two_pi);
         ang -= k * two_pi;
         flip = 0;
         if (ang > half_pi) begin
            ang -= pi_u;
            flip = 1;
         end else if (ang < -half_pi) begin
            ang += pi_u;
            flip = 1;
         end
         x = 652032874;
         y = 0;
         for (int i = 0; i < STAGES && i < 32; i++) begin
            if (ang >= 0) begin
               nx = x - floor_shift(y, i);
               y  = y + floor_shift(x, i);
               ang -= atan_step(i);
            end else begin
               nx = x + floor_shift(y, i);
               y  = y - floor_shift(x, i);
               ang += atan_step(i);
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         s = (30 > FRAC) ? round_shift(y, 30 - FRAC) : y <<< (FRAC - 30);
         c = (30 > FRAC) ? round_shift(x, 30 - FRAC) : x <<< (FRAC - 30);
      endfunction

      function logic signed [15:0] clip_q15(longint acc, inout bit sat);
         longint r;
         r = round_shift(acc, FRAC);
         if (r > 32767) begin
            r = 32767;
            sat = 1;
         end else if (r < -32768) begin
            r = -32768;
            sat = 1;
         end
         return r[15:0];
      endfunction

      function void note_request(req_type rq);
         longint qw, qx, qy, qz, st, sx, cx, sy, cy, sz, cz, dw, dx, dy, dz;
         rsp_type rs;
         bit sat;
         qw = rq.quat_w; qx = rq.quat_x; qy = rq.quat_y; qz = rq.quat_z;
         st = rq.step_angle;
         half_angle_trig(longint'(rq.rate_x) * st * 32, sx, cx);
         half_angle_trig(longint'(rq.rate_y) * st * 32, sy, cy);
         half_angle_trig(longint'(rq.rate_z) * st * 32, sz, cz);
         dw = triple(cx, cy, cz) + triple(sx, sy, sz);
         dx = triple(sx, cy, cz) - triple(cx, sy, sz);
         dy = triple(cx, sy, cz) + triple(sx, cy, sz);
         dz = triple(cx, cy, sz) - triple(sx, sy, cz);
         sat = 0;
         rs.res_w = clip_q15(qw * dw - qx * dx - qy * dy - qz * dz, sat);
         rs.res_x = clip_q15(qw * dx + qx * dw + qy * dz - qz * dy, sat);
         rs.res_y = clip_q15(qw * dy - qx * dz + qy * dw + qz * dx, sat);
         rs.res_z = clip_q15(qw * dz + qx * dy - qy * dx + qz * dw, sat);
         rs.saturated = sat;
         pending_rsp.push_back(rs);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got !== exp_rsp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d s=%0b got w=%0d x=%0d y=%0d z=%0d s=%0b",
                        exp_rsp.res_w, exp_rsp.res_x, exp_rsp.res_y, exp_rsp.res_z,
                        exp_rsp.saturated, got.res_w, got.res_x, got.res_y, got.res_z,
                        got.saturated);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rotation_scoreboard rot_sb;
   bit                 no_idle;

   quaternion_euler_rotate_update #(
      .DATA_WIDTH   (DW),
      .CORDIC_STAGES(STAGES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Sample responses at the edge that ends their strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) rot_sb.check_response(rsp_data);
   end

   // Offer one request; hold start until the block takes it. Start is only
   // lowered after acceptance when an idle cycle follows, so a back-to-back
   // request keeps start high without a lower/raise in one step.
   task automatic send_request(req_type rq);
      start    <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      rot_sb.note_request(rq);
      if (!no_idle && $urandom_range(99) < 9) begin
         start <= 1'b0;
         req_data <= req_type'({$urandom, $urandom, $urandom, $urandom});
         @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rnd16();
      return 16'($urandom);
   endfunction

   // Random request: mostly halved quaternions with reduced step angles, the
   // rest full-range noise to reach clipping and large wrapped angles.
   function automatic req_type random_request();
      req_type rq;
      int mode;
      mode = $urandom_range(9);
      rq.quat_w = rnd16(); rq.quat_x = rnd16(); rq.quat_y = rnd16(); rq.quat_z = rnd16();
      rq.rate_x = rnd16(); rq.rate_y = rnd16(); rq.rate_z = rnd16();
      rq.step_angle = rnd16();
      if (mode < 6) begin
         // shrink quaternion to keep the norm at most one
         rq.quat_w = rq.quat_w >>> 1; rq.quat_x = rq.quat_x >>> 1;
         rq.quat_y = rq.quat_y >>> 1; rq.quat_z = rq.quat_z >>> 1;
         rq.step_angle = rq.step_angle >>> $urandom_range(2, 8);
      end
      return rq;
   endfunction

   function automatic req_type make_req(int w, int x, int y, int z,
                                        int rx, int ry, int rz, int st);
      req_type rq;
      rq.quat_w = 16'(w);   rq.quat_x = 16'(x);   rq.quat_y = 16'(y);   rq.quat_z = 16'(z);
      rq.rate_x = 16'(rx);  rq.rate_y = 16'(ry);  rq.rate_z = 16'(rz);
      rq.step_angle = 16'(st);
      return rq;
   endfunction

   initial begin
      int idle_cnt;
      rot_sb   = new();
      no_idle  = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed corners: identity, field extremes, near -pi/2 half angle,
      // large wrapped angles, and oversized quaternions that clip.
      send_request(make_req(32767, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(-32768, 0, 0, 0, 4096, 0, 0, 4096));
      send_request(make_req(0, 32767, 0, 0, 0, 4096, 0, 4096));
      send_request(make_req(0, 0, -32768, 0, 0, 0, 4096, 4096));
      send_request(make_req(23170, 23170, 0, 0, 4096, 4096, 4096, 1000));
      // rate*step*32 = -pi exactly is not representable; cover near -pi/2
      send_request(make_req(32767, 0, 0, 0, -12868, 0, 0, 4096));
      send_request(make_req(32767, 0, 0, 0, 12868, -12868, 12868, 4096));
      send_request(make_req(32767, 32767, 32767, 32767, 0, 0, 0, 0));
      send_request(make_req(-32768, -32768, -32768, -32768, 0, 0, 0, 0));
      send_request(make_req(32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767));
      send_request(make_req(-32768, 32767, -32768, 32767, -32768, -32768, -32768, -32768));
      send_request(make_req(16384, 16384, 16384, 16384, 32767, -32768, 1, -1));
      send_request(make_req(32767, 0, 0, 0, -32768, -32768, -32768, 32767));
      send_request(make_req(0, 0, 0, 0, 32767, 32767, 32767, 32767));
      send_request(make_req(-1, -1, -1, -1, -1, -1, -1, -1));
      send_request(make_req(1, 1, 1, 1, 1, 1, 1, 1));

      // Random phase, with a stretch in the middle that never idles.
      for (int i = 0; i < N_RAND; i++) begin
         no_idle = (i >= 500 && i < 800);
         send_request(random_request());
      end
      start <= 1'b0;

      // Drain, then allow pipeline latency for stray strobes.
      idle_cnt = 0;
      while (rot_sb.pending_rsp.size() != 0 && idle_cnt < 10 * LAT) begin
         @(posedge clock);
         idle_cnt++;
      end
      repeat (LAT + 5) @(posedge clock);
      if (rot_sb.mismatches == 0 && rot_sb.pending_rsp.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(12 * 200000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== quaternion_euler_rotate_update.f =====
rtl/qeru_pkg.sv
rtl/quaternion_euler_rotate_update.sv
verif/tb_quaternion_euler_rotate_update.sv
